@@ rtl/tccw_pkg.sv @@
// tccw_pkg: shared constants, codes and types of the text console cell writer
// used by every module of the block except tccw_ram; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package tccw_pkg;

   // screen geometry
   localparam int COLUMNS = 80;
   localparam int ROWS    = 25;
   localparam int CELLS   = COLUMNS * ROWS;

   // cell store addressing
   localparam int ADDR_W = $clog2(CELLS);
   localparam int CNT_W  = $clog2(CELLS + 1);
   localparam int CELL_W = 16;

   // fixed field widths
   localparam int CUR_COL_W = 7;
   localparam int CUR_ROW_W = 5;
   localparam int CSR_IDX_W = 2;

   // command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // command codes
   localparam logic [1:0] CMD_PUT   = 2'd0;
   localparam logic [1:0] CMD_BACK  = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;
   localparam logic [1:0] CMD_READ  = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_DEFAULT_COLOR   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ERROR_COLOR     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BACKSPACE_COLOR = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_CLEAR_COLOR     = 2'd3;

   // register reset values
   localparam logic [7:0] DEFAULT_COLOR_RST   = 8'd15;
   localparam logic [7:0] ERROR_COLOR_RST     = 8'd79;
   localparam logic [7:0] BACKSPACE_COLOR_RST = 8'd15;
   localparam logic [7:0] CLEAR_COLOR_RST     = 8'd15;

   // character codes
   localparam logic [7:0] CHAR_NEWLINE  = 8'h0A;
   localparam logic [7:0] CHAR_BLANK_IP = 8'h08;
   localparam logic [7:0] CHAR_SPACE    = 8'h20;
   localparam logic [7:0] CHAR_ERROR    = 8'h45;

   // work the back end carries out for one transaction
   typedef enum logic [1:0] {
      OP_NONE,
      OP_WRITE,
      OP_READ,
      OP_CLEAR
   } op_kind_type;

   typedef struct packed {
      op_kind_type            kind;
      logic                   scroll;
      logic [ADDR_W-1:0]      addr;
      logic [CELL_W-1:0]      data;
      logic [CUR_COL_W-1:0]   cursor_col;
      logic [CUR_ROW_W-1:0]   cursor_row;
      logic                   position_error;
   } op_type;

   typedef struct packed {
      logic [CUR_COL_W-1:0]   cursor_col;
      logic [CUR_ROW_W-1:0]   cursor_row;
      logic                   position_error;
      logic [7:0]             read_char;
      logic [7:0]             read_attr;
   } rsp_type;

   // back end sequencer states
   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_READ,
      ST_SCROLL,
      ST_ZERO,
      ST_CLEAR
   } st_type;

endpackage

`default_nettype wire

@@ rtl/tccw_ram.sv @@
// tccw_ram: generic simple dual-port RAM, one write and one registered read
// standalone, no package needed
`timescale 1ns / 1ps
`default_nettype none

module tccw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  wire                             clock,
   input  wire                             we,
   input  wire  [$clog2(DEPTH)-1:0]        waddr,
   input  wire  [WIDTH-1:0]                wdata,
   input  wire  [$clog2(DEPTH)-1:0]        raddr,
   output logic [WIDTH-1:0]                rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

@@ rtl/tccw_op_queue.sv @@
// tccw_op_queue: short queue of classified operations between front and back
// depends on tccw_pkg
`timescale 1ns / 1ps
`default_nettype none

module tccw_op_queue (
   input  wire                clock,
   input  wire                reset,
   input  wire                push,
   input  tccw_pkg::op_type   push_op,
   output logic               full,
   input  wire                pop,
   output tccw_pkg::op_type   head_op,
   output logic               empty
);
   import tccw_pkg::*;

   op_type              entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign full    = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head_op = entries_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

`default_nettype wire

@@ rtl/tccw_front.sv @@
// tccw_front: accepts transactions, owns cursor and color registers, and
// turns each command into one operation for the back end; depends on tccw_pkg
`timescale 1ns / 1ps
`default_nettype none

module tccw_front (
   input  wire                               clock,
   input  wire                               reset,
   // input transactions
   input  wire                               req_push,
   output logic                              req_full,
   input  wire  [1:0]                        req_command,
   input  wire                               req_at_cursor,
   input  wire  [7:0]                        req_col,
   input  wire  [7:0]                        req_row,
   input  wire  [7:0]                        req_char_code,
   input  wire  [7:0]                        req_attr,
   // register writes
   input  wire                               csr_valid,
   output logic                              csr_ready,
   input  wire  [tccw_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire  [7:0]                        csr_data,
   // toward the back end
   input  wire                               queue_full,
   input  wire                               back_init,
   output logic                              op_push,
   output tccw_pkg::op_type                  op_out
);
   import tccw_pkg::*;

   logic [CUR_COL_W-1:0] cur_col_ff, cur_col_in;
   logic [CUR_ROW_W-1:0] cur_row_ff, cur_row_in;
   logic [7:0]           default_color_ff, error_color_ff;
   logic [7:0]           backspace_color_ff, clear_color_ff;

   logic [7:0]           tgt_col, tgt_row;
   logic                 in_range;
   logic [7:0]           eff_attr, bs_attr;
   logic [8:0]           col_inc, row_inc;
   logic [8:0]           new_col, new_row;
   logic [7:0]           bs_col, bs_row;
   logic                 accept;

   // linear cell index of a column and row
   function automatic logic [ADDR_W-1:0] cell_addr(input logic [7:0] row,
                                                   input logic [7:0] col);
      logic [16:0] lin;
      lin = 17'(row) * 17'(COLUMNS) + 17'(col);
      return lin[ADDR_W-1:0];
   endfunction

   assign req_full  = queue_full || back_init;
   assign accept    = req_push && !req_full;
   assign op_push   = accept;
   assign csr_ready = 1'b1;

   // target cell and range check
   always_comb begin
      if (req_at_cursor) begin
         tgt_col  = 8'(cur_col_ff);
         tgt_row  = 8'(cur_row_ff);
         in_range = 1'b1;
      end else begin
         tgt_col  = req_col;
         tgt_row  = req_row;
         in_range = (9'(req_col) < 9'(COLUMNS)) && (9'(req_row) < 9'(ROWS));
      end
   end

   assign eff_attr = (req_attr == 8'd0) ? default_color_ff : req_attr;
   assign bs_attr  = (backspace_color_ff == 8'd0) ? default_color_ff : backspace_color_ff;
   assign col_inc  = 9'(tgt_col) + 9'd1;
   assign row_inc  = 9'(tgt_row) + 9'd1;

   // cursor one cell back, staying at the first cell
   always_comb begin
      if (cur_col_ff != '0) begin
         bs_col = 8'(cur_col_ff) - 8'd1;
         bs_row = 8'(cur_row_ff);
      end else if (cur_row_ff != '0) begin
         bs_col = 8'(COLUMNS - 1);
         bs_row = 8'(cur_row_ff) - 8'd1;
      end else begin
         bs_col = 8'd0;
         bs_row = 8'd0;
      end
   end

   // classify the command into one back end operation
   always_comb begin
      new_col                = 9'(tgt_col);
      new_row                = 9'(tgt_row);
      op_out.kind            = OP_NONE;
      op_out.scroll          = 1'b0;
      op_out.addr            = cell_addr(tgt_row, tgt_col);
      op_out.data            = {eff_attr, req_char_code};
      op_out.position_error  = 1'b0;
      cur_col_in             = cur_col_ff;
      cur_row_in             = cur_row_ff;
      unique case (req_command)
         CMD_PUT: begin
            if (!in_range) begin
               op_out.kind           = OP_WRITE;
               op_out.addr           = ADDR_W'(CELLS - 1);
               op_out.data           = {error_color_ff, CHAR_ERROR};
               op_out.position_error = 1'b1;
            end else begin
               if (req_char_code == CHAR_NEWLINE) begin
                  new_col = 9'd0;
                  new_row = row_inc;
               end else if (req_char_code == CHAR_BLANK_IP) begin
                  op_out.kind = OP_WRITE;
                  op_out.data = {eff_attr, CHAR_SPACE};
               end else begin
                  op_out.kind = OP_WRITE;
                  if (col_inc == 9'(COLUMNS)) begin
                     new_col = 9'd0;
                     new_row = row_inc;
                  end else begin
                     new_col = col_inc;
                  end
               end
               // past the last cell the screen scrolls up one row
               if (new_row == 9'(ROWS)) begin
                  op_out.scroll = 1'b1;
                  new_row       = 9'(ROWS - 1);
               end
               cur_col_in = CUR_COL_W'(new_col);
               cur_row_in = CUR_ROW_W'(new_row);
            end
         end
         CMD_BACK: begin
            op_out.kind = OP_WRITE;
            op_out.addr = cell_addr(bs_row, bs_col);
            op_out.data = {bs_attr, CHAR_SPACE};
            cur_col_in  = CUR_COL_W'(bs_col);
            cur_row_in  = CUR_ROW_W'(bs_row);
         end
         CMD_CLEAR: begin
            op_out.kind = OP_CLEAR;
            op_out.data = {clear_color_ff, CHAR_SPACE};
            cur_col_in  = '0;
            cur_row_in  = '0;
         end
         CMD_READ: begin
            if (in_range) begin
               op_out.kind = OP_READ;
            end else begin
               op_out.position_error = 1'b1;
            end
         end
         default: begin
            op_out.kind = OP_NONE;
         end
      endcase
      op_out.cursor_col = cur_col_in;
      op_out.cursor_row = cur_row_in;
   end

   // cursor register, moved on each accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_col_ff <= '0;
         cur_row_ff <= '0;
      end else if (accept) begin
         cur_col_ff <= cur_col_in;
         cur_row_ff <= cur_row_in;
      end
   end

   // color registers
   always_ff @(posedge clock) begin
      if (reset) begin
         default_color_ff   <= DEFAULT_COLOR_RST;
         error_color_ff     <= ERROR_COLOR_RST;
         backspace_color_ff <= BACKSPACE_COLOR_RST;
         clear_color_ff     <= CLEAR_COLOR_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_DEFAULT_COLOR:   default_color_ff   <= csr_data;
            REG_ERROR_COLOR:     error_color_ff     <= csr_data;
            REG_BACKSPACE_COLOR: backspace_color_ff <= csr_data;
            REG_CLEAR_COLOR:     clear_color_ff     <= csr_data;
            default: begin
               default_color_ff <= default_color_ff;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

@@ rtl/tccw_back.sv @@
// tccw_back: sequencer that carries out operations on the cell store
// (write, read, scroll, clear, clearing pass) and holds the result register
// depends on tccw_pkg and tccw_ram
`timescale 1ns / 1ps
`default_nettype none

module tccw_back (
   input  wire                clock,
   input  wire                reset,
   // from the operation queue
   input  wire                op_valid,
   input  tccw_pkg::op_type   op_head,
   output logic               op_pop,
   // status toward the front
   output logic               back_init,
   // result transactions
   output logic               rsp_empty,
   input  wire                rsp_pop,
   output tccw_pkg::rsp_type  rsp_out
);
   import tccw_pkg::*;

   st_type              state_ff, state_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   op_type              op_ff, op_in;
   rsp_type             rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic                ram_we;
   logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
   logic [CELL_W-1:0]   ram_wdata, ram_rdata;
   logic                start, rsp_push, rsp_taken, cnt_last;
   rsp_type             rsp_data;
   logic [CNT_W-1:0]    copy_dst;

   tccw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELLS)
   ) u_cells (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign rsp_taken = rsp_pop && rsp_valid_ff;
   assign start     = (state_ff == ST_IDLE) && op_valid && (!rsp_valid_ff || rsp_taken);
   assign cnt_last  = (cnt_ff == CNT_W'(CELLS - 1));
   assign copy_dst  = cnt_ff - CNT_W'(COLUMNS + 1);
   assign back_init = (state_ff == ST_INIT);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT: begin
            if (cnt_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               unique case (op_head.kind)
                  OP_READ:  state_in = ST_READ;
                  OP_CLEAR: state_in = ST_CLEAR;
                  default:  state_in = op_head.scroll ? ST_SCROLL : ST_IDLE;
               endcase
            end
         end
         ST_READ: begin
            state_in = ST_IDLE;
         end
         ST_SCROLL: begin
            if (cnt_ff == CNT_W'(CELLS)) state_in = ST_ZERO;
         end
         ST_ZERO: begin
            if (cnt_last) state_in = ST_IDLE;
         end
         ST_CLEAR: begin
            if (cnt_last) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // memory ports, counter and result push
   always_comb begin
      ram_we                  = 1'b0;
      ram_waddr               = cnt_ff[ADDR_W-1:0];
      ram_wdata               = '0;
      ram_raddr               = cnt_ff[ADDR_W-1:0];
      op_pop                  = 1'b0;
      op_in                   = op_ff;
      cnt_in                  = cnt_ff;
      rsp_push                = 1'b0;
      rsp_data.cursor_col     = op_ff.cursor_col;
      rsp_data.cursor_row     = op_ff.cursor_row;
      rsp_data.position_error = op_ff.position_error;
      rsp_data.read_char      = 8'd0;
      rsp_data.read_attr      = 8'd0;
      unique case (state_ff)
         ST_INIT: begin
            // clearing pass after reset
            ram_we = 1'b1;
            cnt_in = cnt_ff + CNT_W'(1);
         end
         ST_IDLE: begin
            ram_raddr = op_head.addr;
            if (start) begin
               op_pop                  = 1'b1;
               op_in                   = op_head;
               rsp_data.cursor_col     = op_head.cursor_col;
               rsp_data.cursor_row     = op_head.cursor_row;
               rsp_data.position_error = op_head.position_error;
               if (op_head.kind == OP_WRITE) begin
                  ram_we    = 1'b1;
                  ram_waddr = op_head.addr;
                  ram_wdata = op_head.data;
               end
               if (op_head.kind == OP_CLEAR) begin
                  cnt_in = '0;
               end else if (op_head.kind != OP_READ) begin
                  if (op_head.scroll) begin
                     cnt_in = CNT_W'(COLUMNS);
                  end else begin
                     rsp_push = 1'b1;
                  end
               end
            end
         end
         ST_READ: begin
            rsp_push           = 1'b1;
            rsp_data.read_char = ram_rdata[7:0];
            rsp_data.read_attr = ram_rdata[15:8];
         end
         ST_SCROLL: begin
            // read one row below, write the registered read data one row higher
            if (cnt_ff > CNT_W'(COLUMNS)) begin
               ram_we    = 1'b1;
               ram_waddr = copy_dst[ADDR_W-1:0];
               ram_wdata = ram_rdata;
            end
            if (cnt_ff == CNT_W'(CELLS)) begin
               cnt_in = CNT_W'(CELLS - COLUMNS);
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_ZERO: begin
            // blank the last row
            ram_we   = 1'b1;
            cnt_in   = cnt_ff + CNT_W'(1);
            rsp_push = cnt_last;
         end
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_wdata = op_ff.data;
            cnt_in    = cnt_ff + CNT_W'(1);
            rsp_push  = cnt_last;
         end
         default: begin
            ram_we = 1'b0;
         end
      endcase
   end

   // result register
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_push) begin
         rsp_in       = rsp_data;
         rsp_valid_in = 1'b1;
      end else if (rsp_taken) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_empty = !rsp_valid_ff;
   assign rsp_out   = rsp_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      rsp_ff <= rsp_in;
   end

endmodule

`default_nettype wire

@@ rtl/text_console_cell_writer.sv @@
// text_console_cell_writer: top level of the text console engine
// depends on tccw_pkg, tccw_front, tccw_op_queue and tccw_back
`timescale 1ns / 1ps
`default_nettype none

// Text console with an 80x25 store of character/attribute cells and a cursor.
// Transactions go in through a push/full port and each gives one result on
// an empty/pop port. The front end classifies a command and moves the cursor
// in the cycle it is accepted, and a two-entry operation queue lets it run
// ahead of the back end, which owns the cell store (one write and one
// registered read port). In the back end a put or backspace is written in the
// cycle it starts, a read gives its result from the read state, a clear screen
// writes one cell per cycle, and a put that scrolls copies the rows up, then blanks the last row.
// The back end starts an operation only once the result register is free, so
// a result that is not popped holds it, and full rises once the queue fills.
// After reset a clearing pass zeroes the store, during which full stays
// high; register writes are taken at any time.
module text_console_cell_writer (
   input  wire                               clock,
   input  wire                               reset,
   // input transactions
   input  wire                               req_push,
   output logic                              req_full,
   input  wire  [1:0]                        req_command,
   input  wire                               req_at_cursor,
   input  wire  [7:0]                        req_col,
   input  wire  [7:0]                        req_row,
   input  wire  [7:0]                        req_char_code,
   input  wire  [7:0]                        req_attr,
   // result transactions
   output logic                              rsp_empty,
   input  wire                               rsp_pop,
   output logic [tccw_pkg::CUR_COL_W-1:0]    rsp_cursor_col,
   output logic [tccw_pkg::CUR_ROW_W-1:0]    rsp_cursor_row,
   output logic                              rsp_position_error,
   output logic [7:0]                        rsp_read_char,
   output logic [7:0]                        rsp_read_attr,
   // register writes
   input  wire                               csr_valid,
   output logic                              csr_ready,
   input  wire  [tccw_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire  [7:0]                        csr_data
);
   import tccw_pkg::*;

   op_type  front_op, head_op;
   logic    front_push, queue_full, queue_empty, queue_pop, back_init;
   rsp_type rsp;

   // front end: accept and classify
   tccw_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_command   (req_command),
      .req_at_cursor (req_at_cursor),
      .req_col       (req_col),
      .req_row       (req_row),
      .req_char_code (req_char_code),
      .req_attr      (req_attr),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .queue_full    (queue_full),
      .back_init     (back_init),
      .op_push       (front_push),
      .op_out        (front_op)
   );

   // operation queue
   tccw_op_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (front_push),
      .push_op (front_op),
      .full    (queue_full),
      .pop     (queue_pop),
      .head_op (head_op),
      .empty   (queue_empty)
   );

   // back end: cell store sequencer
   tccw_back u_back (
      .clock     (clock),
      .reset     (reset),
      .op_valid  (!queue_empty),
      .op_head   (head_op),
      .op_pop    (queue_pop),
      .back_init (back_init),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_out   (rsp)
   );

   // result fields
   assign rsp_cursor_col     = rsp.cursor_col;
   assign rsp_cursor_row     = rsp.cursor_row;
   assign rsp_position_error = rsp.position_error;
   assign rsp_read_char      = rsp.read_char;
   assign rsp_read_attr      = rsp.read_attr;

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
// tb_top: self-checking bench for the text console cell writer
// drives the push/full, empty/pop and csr ports; depends on tccw_pkg and the rtl top
`timescale 1ns / 1ps

module tb_top;
   import tccw_pkg::*;

   localparam int CYCLE_LIMIT = 4_500_000;
   // wait before register writes once a phase has drained
   localparam int SETTLE_CYCLES = 2100;
   localparam int TAIL_CYCLES = 100;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                 req_push      = 1'b0;
   logic                 req_full;
   logic [1:0]           req_command   = CMD_PUT;
   logic                 req_at_cursor = 1'b0;
   logic [7:0]           req_col       = 8'd0;
   logic [7:0]           req_row       = 8'd0;
   logic [7:0]           req_char_code = 8'd0;
   logic [7:0]           req_attr      = 8'd0;

   logic                 rsp_empty;
   logic                 rsp_pop       = 1'b0;
   logic [CUR_COL_W-1:0] rsp_cursor_col;
   logic [CUR_ROW_W-1:0] rsp_cursor_row;
   logic                 rsp_position_error;
   logic [7:0]           rsp_read_char;
   logic [7:0]           rsp_read_attr;

   logic                 csr_valid     = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index     = REG_DEFAULT_COLOR;
   logic [7:0]           csr_data      = 8'd0;

   // console model: cell store, cursor and color registers
   logic [15:0] screen_cells [0:CELLS-1];
   int          cursor_pos;
   logic [7:0]  color_default;
   logic [7:0]  color_error;
   logic [7:0]  color_backspace;
   logic [7:0]  color_clear;

   rsp_type pending_rsp [$];
   int      errors = 0;
   int      cycle_count = 0;
   bit      quiet = 1'b0;
   int      stall_left = 0;

   text_console_cell_writer dut (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_command        (req_command),
      .req_at_cursor      (req_at_cursor),
      .req_col            (req_col),
      .req_row            (req_row),
      .req_char_code      (req_char_code),
      .req_attr           (req_attr),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_cursor_col     (rsp_cursor_col),
      .rsp_cursor_row     (rsp_cursor_row),
      .rsp_position_error (rsp_position_error),
      .rsp_read_char      (rsp_read_char),
      .rsp_read_attr      (rsp_read_attr),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // cycle limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // runs one command on the console model and returns its result
   function automatic rsp_type console_step(logic [1:0] cmd, logic atc, logic [7:0] col,
                                            logic [7:0] row, logic [7:0] ch,
                                            logic [7:0] attr_in);
      rsp_type    r;
      int         pos;
      bit         in_range;
      logic [7:0] at;
      r = '0;
      pos = 0;
      in_range = 1'b1;
      // target cell: cursor or given column and row
      if (atc)
         pos = cursor_pos;
      else if (col >= COLUMNS || row >= ROWS)
         in_range = 1'b0;
      else
         pos = row * COLUMNS + col;
      case (cmd)
         CMD_PUT: begin
            if (!in_range) begin
               screen_cells[CELLS-1] = {color_error, CHAR_ERROR};
               r.position_error = 1'b1;
            end else begin
               at = (attr_in != 8'd0) ? attr_in : color_default;
               if (ch == CHAR_NEWLINE) begin
                  pos = (pos / COLUMNS + 1) * COLUMNS;
               end else if (ch == CHAR_BLANK_IP) begin
                  screen_cells[pos] = {at, CHAR_SPACE};
               end else begin
                  screen_cells[pos] = {at, ch};
                  pos++;
               end
               // past the last cell: rows move up, last row zeroed
               if (pos >= CELLS) begin
                  for (int i = 0; i < CELLS - COLUMNS; i++)
                     screen_cells[i] = screen_cells[i + COLUMNS];
                  for (int i = CELLS - COLUMNS; i < CELLS; i++)
                     screen_cells[i] = 16'd0;
                  pos -= COLUMNS;
               end
               cursor_pos = pos;
            end
         end
         CMD_BACK: begin
            pos = (cursor_pos > 0) ? cursor_pos - 1 : 0;
            at = (color_backspace != 8'd0) ? color_backspace : color_default;
            screen_cells[pos] = {at, CHAR_SPACE};
            cursor_pos = pos;
         end
         CMD_CLEAR: begin
            for (int i = 0; i < CELLS; i++)
               screen_cells[i] = {color_clear, CHAR_SPACE};
            cursor_pos = 0;
         end
         default: begin
            if (!in_range) begin
               r.position_error = 1'b1;
            end else begin
               r.read_char = screen_cells[pos][7:0];
               r.read_attr = screen_cells[pos][15:8];
            end
         end
      endcase
      r.cursor_col = CUR_COL_W'(cursor_pos % COLUMNS);
      r.cursor_row = CUR_ROW_W'(cursor_pos / COLUMNS);
      return r;
   endfunction

   // sender gap: mostly none, some short, a few long
   function automatic int pick_gap();
      int r;
      if (quiet)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 65)
         return 0;
      if (r < 95)
         return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // one input transaction; returns at the edge where it is taken
   task automatic send_cmd(logic [1:0] cmd, logic atc, logic [7:0] col, logic [7:0] row,
                           logic [7:0] ch, logic [7:0] attr_in);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_push = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_command   = cmd;
      req_at_cursor = atc;
      req_col       = col;
      req_row       = row;
      req_char_code = ch;
      req_attr      = attr_in;
      req_push      = 1'b1;
      do @(posedge clock); while (req_full);
      pending_rsp.push_back(console_step(cmd, atc, col, row, ch, attr_in));
   endtask

   // stop sending and wait for every expected result
   task automatic wait_drained();
      @(negedge clock);
      req_push = 1'b0;
      while (pending_rsp.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [7:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_DEFAULT_COLOR:   color_default   = value;
         REG_ERROR_COLOR:     color_error     = value;
         REG_BACKSPACE_COLOR: color_backspace = value;
         default:             color_clear     = value;
      endcase
   endtask

   // new color setting, only once the block is idle
   task automatic set_colors(logic [7:0] dflt, logic [7:0] err, logic [7:0] bsp,
                             logic [7:0] clr);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      write_csr(REG_DEFAULT_COLOR, dflt);
      write_csr(REG_ERROR_COLOR, err);
      write_csr(REG_BACKSPACE_COLOR, bsp);
      write_csr(REG_CLEAR_COLOR, clr);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // random command, biased toward the last row so that scrolls happen
   task automatic random_item();
      int         sel;
      logic [1:0] cmd;
      logic       atc;
      logic [7:0] col, row, ch, at;
      sel = $urandom_range(0, 99);
      if (sel < 75)
         cmd = CMD_PUT;
      else if (sel < 83)
         cmd = CMD_BACK;
      else if (sel < 85)
         cmd = CMD_CLEAR;
      else
         cmd = CMD_READ;
      atc = ($urandom_range(0, 9) < 6);
      if ($urandom_range(0, 9) < 8)
         col = 8'($urandom_range(0, COLUMNS - 1));
      else
         col = 8'($urandom_range(COLUMNS, 255));
      sel = $urandom_range(0, 9);
      if (sel < 2)
         row = 8'(ROWS - 1);
      else if (sel < 8)
         row = 8'($urandom_range(0, ROWS - 1));
      else
         row = 8'($urandom_range(ROWS, 255));
      sel = $urandom_range(0, 19);
      if (sel < 2)
         ch = CHAR_NEWLINE;
      else if (sel < 3)
         ch = CHAR_BLANK_IP;
      else
         ch = 8'($urandom_range(0, 255));
      at = ($urandom_range(0, 4) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
      send_cmd(cmd, atc, col, row, ch, at);
   endtask

   // random traffic with stretches now and then of no gaps and no result stalls
   task automatic random_phase(int count);
      for (int n = 0; n < count; n++) begin
         if (n % 30 == 0)
            quiet = ($urandom_range(0, 9) < 3);
         random_item();
      end
      quiet = 1'b0;
   endtask

   // result stall: mostly short, a few long
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_pop = 1'b0;
         stall_left--;
      end else if (!quiet && $urandom_range(0, 99) < 15) begin
         rsp_pop = 1'b0;
         stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(0, 2);
      end else begin
         rsp_pop = 1'b1;
      end
   end

   task automatic check_field(string name, int exp_v, int act_v);
      if (exp_v != act_v) begin
         errors++;
         $display("%0t %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
      end
   endtask

   // compare each popped result with the oldest expectation
   always @(posedge clock) begin : rsp_check
      rsp_type exp_r;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_rsp.size() == 0) begin
            errors++;
            $display("%0t unexpected result: expected none, actual col %0d row %0d",
                     $time, rsp_cursor_col, rsp_cursor_row);
         end else begin
            exp_r = pending_rsp.pop_front();
            check_field("cursor_col", int'(exp_r.cursor_col), int'(rsp_cursor_col));
            check_field("cursor_row", int'(exp_r.cursor_row), int'(rsp_cursor_row));
            check_field("position_error", int'(exp_r.position_error),
                        int'(rsp_position_error));
            check_field("read_char", int'(exp_r.read_char), int'(rsp_read_char));
            check_field("read_attr", int'(exp_r.read_attr), int'(rsp_read_attr));
         end
      end
   end

   // store is zero after reset, edge reads and out-of-range reads
   task automatic test_reset_state();
      send_cmd(CMD_READ, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0);
      send_cmd(CMD_READ, 1'b0, 8'd79, 8'd24, 8'd0, 8'd0);
      send_cmd(CMD_READ, 1'b0, 8'd80, 8'd24, 8'd0, 8'd0);
      send_cmd(CMD_READ, 1'b0, 8'd0, 8'd25, 8'd0, 8'd0);
      send_cmd(CMD_READ, 1'b1, 8'd255, 8'd255, 8'hFF, 8'hFF);
   endtask

   // puts at cursor and at a given cell, newline, blank in place, default color
   task automatic test_put();
      send_cmd(CMD_PUT, 1'b1, 8'd0, 8'd0, 8'h41, 8'd0);
      send_cmd(CMD_PUT, 1'b1, 8'd0, 8'd0, 8'hFF, 8'hFF);
      send_cmd(CMD_PUT, 1'b1, 8'd0, 8'd0, 8'h00, 8'h01);
      send_cmd(CMD_PUT, 1'b1, 8'd0, 8'd0, CHAR_NEWLINE, 8'd0);
      send_cmd(CMD_PUT, 1'b1, 8'd0, 8'd0, CHAR_BLANK_IP, 8'h80);
      send_cmd(CMD_PUT, 1'b0, 8'd79, 8'd0, 8'h7A, 8'h7F);
      send_cmd(CMD_READ, 1'b1, 8'd0, 8'd0, 8'd0, 8'd0);
   endtask

   // out-of-range put marks the last cell, cursor mode never flags
   task automatic test_error_marker();
      send_cmd(CMD_PUT, 1'b0, 8'd80, 8'd0, 8'h41, 8'h11);
      send_cmd(CMD_PUT, 1'b0, 8'd255, 8'd255, 8'h42, 8'd0);
      send_cmd(CMD_READ, 1'b0, 8'd79, 8'd24, 8'd0, 8'd0);
      send_cmd(CMD_PUT, 1'b1, 8'd255, 8'd255, 8'h71, 8'h22);
   endtask

   // put into the last cell and newline on the last row both scroll
   task automatic test_scroll();
      send_cmd(CMD_PUT, 1'b0, 8'd79, 8'd24, 8'h78, 8'h33);
      send_cmd(CMD_PUT, 1'b1, 8'd0, 8'd0, CHAR_NEWLINE, 8'd0);
      send_cmd(CMD_READ, 1'b0, 8'd79, 8'd22, 8'd0, 8'd0);
   endtask

   // backspace, clear screen, backspace at the first cell
   task automatic test_backspace_clear();
      send_cmd(CMD_BACK, 1'b0, 8'd255, 8'd255, 8'hFF, 8'hFF);
      send_cmd(CMD_CLEAR, 1'b0, 8'd255, 8'd255, 8'hFF, 8'hFF);
      send_cmd(CMD_BACK, 1'b1, 8'd0, 8'd0, 8'd0, 8'd0);
      send_cmd(CMD_READ, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0);
      send_cmd(CMD_READ, 1'b0, 8'd40, 8'd12, 8'd0, 8'd0);
   endtask

   // all registers at zero, then at all ones
   task automatic test_color_extremes();
      set_colors(8'd0, 8'd0, 8'd0, 8'd0);
      random_phase(60);
      set_colors(8'hFF, 8'hFF, 8'hFF, 8'hFF);
      random_phase(60);
   endtask

   // random settings, one of them with the backspace color falling back
   task automatic test_random_traffic();
      set_colors(8'($urandom_range(1, 255)), 8'($urandom_range(0, 255)), 8'd0,
                 8'($urandom_range(0, 255)));
      random_phase(110);
      set_colors(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      random_phase(110);
      set_colors(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      random_phase(110);
   endtask

   initial begin
      for (int i = 0; i < CELLS; i++)
         screen_cells[i] = 16'd0;
      cursor_pos      = 0;
      color_default   = DEFAULT_COLOR_RST;
      color_error     = ERROR_COLOR_RST;
      color_backspace = BACKSPACE_COLOR_RST;
      color_clear     = CLEAR_COLOR_RST;
      repeat (6) @(negedge clock);
      reset = 1'b0;

      test_reset_state();
      test_put();
      test_error_marker();
      test_scroll();
      test_backspace_clear();
      test_color_extremes();
      test_random_traffic();

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
